/* design/dwg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dwg_pkg;

    localparam int ACC_BITS   = 28;
    localparam int PHASE_BITS = 12;

    localparam int WORD_BITS  = 16;
    localparam int DATA_BITS  = 14;
    localparam int FREQ_BITS  = 28;
    localparam int PWORD_BITS = 12;
    localparam int PIDX_BITS  = 12;
    localparam int TRI_BITS   = 10;
    localparam int WAVE_BITS  = 2;

    // control register bit positions
    localparam int C_MODE    = 1;
    localparam int C_DIV2    = 3;
    localparam int C_OPBITEN = 5;
    localparam int C_SLEEP12 = 6;
    localparam int C_SLEEP1  = 7;
    localparam int C_RESET   = 8;
    localparam int C_PSELECT = 10;
    localparam int C_FSELECT = 11;
    localparam int C_HLB     = 12;
    localparam int C_B28     = 13;

    // request kinds
    localparam logic [1:0] KIND_CTRL  = 2'd0;
    localparam logic [1:0] KIND_FREQ  = 2'd1;
    localparam logic [1:0] KIND_PHASE = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // serial address field
    localparam logic [1:0] ADDR_CTRL  = 2'd0;
    localparam logic [1:0] ADDR_PHASE = 2'd3;

    localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 sel;
        logic [DATA_BITS-1:0] data;
    } cmd_t;

endpackage

`default_nettype wire

/* design/dds_waveform_generator_regs_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// DDS core with serial register file. Each request is a 16-bit command word
// or one master-clock tick, and each returns one result showing the state
// after it. One request per cycle is sustained while the downstream side takes
// results; a request is held first in the two-entry request queue, then its
// result in the back end's result register, where all state updates and the
// phase add happen in the same cycle. in_ready falls only when the queue is
// full behind a result that the downstream side is not taking.
module dds_waveform_generator_regs_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           op,
    input  wire logic [dwg_pkg::WORD_BITS-1:0]  word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [dwg_pkg::PIDX_BITS-1:0]       phase_index,
    output logic [dwg_pkg::TRI_BITS-1:0]        triangle_code,
    output logic                                square_bit,
    output logic [dwg_pkg::WAVE_BITS-1:0]       waveform,
    output logic                                dac_asleep,
    output logic [dwg_pkg::DATA_BITS-1:0]       control_readback
);
    import dwg_pkg::*;

    logic head_valid;
    cmd_t head;
    logic pop;

    dwg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .word       (word),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    dwg_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .phase_index      (phase_index),
        .triangle_code    (triangle_code),
        .square_bit       (square_bit),
        .waveform         (waveform),
        .dac_asleep       (dac_asleep),
        .control_readback (control_readback)
    );

    // a full queue only builds up behind a stalled result
    a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request queue full without a pending result");

    a_reset_clears_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && control_readback[C_RESET] && !control_readback[C_DIV2]
        |-> !square_bit)
        else $error("square divider not held clear under RESET");

    a_wave_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (waveform == WAVE_SINE || waveform == WAVE_TRIANGLE
                       || waveform == WAVE_SQUARE))
        else $error("illegal waveform select");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("back end took from an empty queue");

endmodule

`default_nettype wire

/* design/dwg_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwg_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         op,
    input  wire logic [dwg_pkg::WORD_BITS-1:0] word,
    output logic                              head_valid,
    output dwg_pkg::cmd_t                     head,
    input  wire logic                         pop
);
    import dwg_pkg::*;

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd;
    logic       push;
    logic       do_pop;

    // classify the incoming request
    always_comb
    begin
        cmd.data = word[DATA_BITS-1:0];
        cmd.sel  = 1'b0;
        cmd.kind = KIND_TICK;
        if (!op)
        begin
            priority if (word[15:14] == ADDR_CTRL)
            begin
                cmd.kind = KIND_CTRL;
            end
            else if (word[15:14] == ADDR_PHASE)
            begin
                cmd.kind = KIND_PHASE;
                cmd.sel  = word[13];
            end
            else
            begin
                cmd.kind = KIND_FREQ;
                cmd.sel  = word[15];
            end
        end
    end

    assign in_ready   = (count_reg != 2'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign do_pop     = pop && head_valid;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

/* design/dwg_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwg_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           head_valid,
    input  wire dwg_pkg::cmd_t                  head,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [dwg_pkg::PIDX_BITS-1:0]       phase_index,
    output logic [dwg_pkg::TRI_BITS-1:0]        triangle_code,
    output logic                                square_bit,
    output logic [dwg_pkg::WAVE_BITS-1:0]       waveform,
    output logic                                dac_asleep,
    output logic [dwg_pkg::DATA_BITS-1:0]       control_readback
);
    import dwg_pkg::*;

    logic [DATA_BITS-1:0]  ctrl_reg, ctrl_next;
    logic [FREQ_BITS-1:0]  freq_reg [2];
    logic [FREQ_BITS-1:0]  freq_next [2];
    logic [PWORD_BITS-1:0] pword_reg [2];
    logic [PWORD_BITS-1:0] pword_next [2];
    logic                  pend_reg, pend_next;
    logic [DATA_BITS-1:0]  pend_low_reg, pend_low_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                  div_reg, div_next;
    logic                  msb_reg, msb_next;
    logic                  out_valid_reg, out_valid_next;

    logic [PIDX_BITS-1:0]  pidx_reg;
    logic [TRI_BITS-1:0]   tri_reg;
    logic                  sq_reg;
    logic [WAVE_BITS-1:0]  wave_reg;
    logic                  asleep_reg;
    logic [DATA_BITS-1:0]  rdbk_reg;

    logic [ACC_BITS+FREQ_BITS-1:0]    freq_ext;
    logic [PHASE_BITS+PWORD_BITS-1:0] pword_ext;
    logic [PHASE_BITS-1:0]            phase;
    logic [PHASE_BITS+TRI_BITS-1:0]   tri_wide;
    logic [PHASE_BITS+PIDX_BITS-1:0]  pidx_ext;
    logic [TRI_BITS-1:0]              tri_code;
    logic [PIDX_BITS-1:0]             pidx_val;
    logic [WAVE_BITS-1:0]             wave_val;
    logic                             take;

    assign take = head_valid && (!out_valid_reg || out_ready);
    assign pop  = take;

    always_comb
    begin
        ctrl_next     = ctrl_reg;
        freq_next     = freq_reg;
        pword_next    = pword_reg;
        pend_next     = pend_reg;
        pend_low_next = pend_low_reg;
        acc_next      = acc_reg;
        freq_ext      = {{ACC_BITS{1'b0}}, freq_reg[ctrl_reg[C_FSELECT]]};

        unique case (head.kind)
            KIND_CTRL:
            begin
                ctrl_next = head.data;
                pend_next = 1'b0;
                if (head.data[C_RESET])
                begin
                    acc_next = '0;
                end
            end
            KIND_PHASE:
            begin
                pword_next[head.sel] = head.data[PWORD_BITS-1:0];
            end
            KIND_FREQ:
            begin
                priority if (ctrl_reg[C_B28])
                begin
                    if (!pend_reg)
                    begin
                        pend_low_next = head.data;
                        pend_next     = 1'b1;
                    end
                    else
                    begin
                        freq_next[head.sel] = {head.data, pend_low_reg};
                        pend_next           = 1'b0;
                    end
                end
                else if (ctrl_reg[C_HLB])
                begin
                    freq_next[head.sel][FREQ_BITS-1:DATA_BITS] = head.data;
                end
                else
                begin
                    freq_next[head.sel][DATA_BITS-1:0] = head.data;
                end
            end
            KIND_TICK:
            begin
                priority if (ctrl_reg[C_RESET])
                begin
                    acc_next = '0;
                end
                else if (!ctrl_reg[C_SLEEP1])
                begin
                    acc_next = acc_reg + freq_ext[ACC_BITS-1:0];
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase

        // phase after this request
        pword_ext = {{PHASE_BITS{1'b0}}, pword_next[ctrl_next[C_PSELECT]]};
        phase     = acc_next[ACC_BITS-1 -: PHASE_BITS] + pword_ext[PHASE_BITS-1:0];
        msb_next  = phase[PHASE_BITS-1];

        // divider toggles on a rising phase MSB, held clear under RESET
        div_next = ctrl_next[C_RESET] ? 1'b0 : (div_reg ^ (!msb_reg && msb_next));

        // ten bits below the MSB, left-justified when the phase is narrow
        tri_wide = {phase, {TRI_BITS{1'b0}}};
        tri_code = tri_wide[PHASE_BITS+TRI_BITS-2 -: TRI_BITS];
        if (msb_next)
        begin
            tri_code = ~tri_code;
        end

        pidx_ext = {{PIDX_BITS{1'b0}}, phase};
        pidx_val = pidx_ext[PIDX_BITS-1:0];

        priority if (ctrl_next[C_OPBITEN])
        begin
            wave_val = WAVE_SQUARE;
        end
        else if (ctrl_next[C_MODE])
        begin
            wave_val = WAVE_TRIANGLE;
        end
        else
        begin
            wave_val = WAVE_SINE;
        end

        out_valid_next = take || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            freq_reg[0]   <= '0;
            freq_reg[1]   <= '0;
            pword_reg[0]  <= '0;
            pword_reg[1]  <= '0;
            pend_reg      <= 1'b0;
            pend_low_reg  <= '0;
            acc_reg       <= '0;
            div_reg       <= 1'b0;
            msb_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                ctrl_reg     <= ctrl_next;
                freq_reg     <= freq_next;
                pword_reg    <= pword_next;
                pend_reg     <= pend_next;
                pend_low_reg <= pend_low_next;
                acc_reg      <= acc_next;
                div_reg      <= div_next;
                msb_reg      <= msb_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pidx_reg   <= pidx_val;
            tri_reg    <= tri_code;
            sq_reg     <= ctrl_next[C_DIV2] ? msb_next : div_next;
            wave_reg   <= wave_val;
            asleep_reg <= ctrl_next[C_SLEEP12];
            rdbk_reg   <= ctrl_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign phase_index      = pidx_reg;
    assign triangle_code    = tri_reg;
    assign square_bit       = sq_reg;
    assign waveform         = wave_reg;
    assign dac_asleep       = asleep_reg;
    assign control_readback = rdbk_reg;

endmodule

`default_nettype wire

/* tb/dds_waveform_generator_regs_core_test.sv */
`timescale 1ns / 1ps

module dds_waveform_generator_regs_core_test;

    import dwg_pkg::*;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] ADDR_FREQ0 = 2'd1;
    localparam logic [1:0] ADDR_FREQ1 = 2'd2;

    localparam int RANDOM_REQUESTS = 830;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [PIDX_BITS-1:0] pidx;
        logic [TRI_BITS-1:0]  tcode;
        logic                 sq;
        logic [WAVE_BITS-1:0] wsel;
        logic                 asleep;
        logic [DATA_BITS-1:0] ctl;
    } synth_out_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   op        = 1'b0;
    logic [WORD_BITS-1:0]   word      = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [PIDX_BITS-1:0]   phase_index;
    logic [TRI_BITS-1:0]    triangle_code;
    logic                   square_bit;
    logic [WAVE_BITS-1:0]   waveform;
    logic                   dac_asleep;
    logic [DATA_BITS-1:0]   control_readback;

    // synthesizer state as the predictor sees it
    logic [DATA_BITS-1:0]   ctl_reg = '0;
    logic [FREQ_BITS-1:0]   freq_word [2] = '{default: '0};
    logic [PWORD_BITS-1:0]  pword [2] = '{default: '0};
    logic                   half_pending = 1'b0;
    logic [DATA_BITS-1:0]   half_low = '0;
    logic [ACC_BITS-1:0]    acc = '0;
    logic                   divider = 1'b0;

    synth_out_t expected_results [$];

    bit idle_on = 1'b1;
    int requests_sent;
    int ticks_sent;
    int results_checked;
    int mismatch_count;
    int quiet_cycles;

    dds_waveform_generator_regs_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .word             (word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .phase_index      (phase_index),
        .triangle_code    (triangle_code),
        .square_bit       (square_bit),
        .waveform         (waveform),
        .dac_asleep       (dac_asleep),
        .control_readback (control_readback)
    );

    always #5 clk = ~clk;

    function automatic logic [PIDX_BITS-1:0] phase_now();
        return acc[ACC_BITS-1 -: PHASE_BITS] + pword[ctl_reg[C_PSELECT]];
    endfunction

    // advances the predicted synthesizer by one request, returns the state after it
    function automatic synth_out_t synth_step(input logic kind, input logic [WORD_BITS-1:0] w);
        logic                 prev_msb;
        logic [PIDX_BITS-1:0] p;
        logic [1:0]           addr;
        logic                 idx;
        logic [DATA_BITS-1:0] d;
        synth_out_t           r;
        p = phase_now();
        prev_msb = p[PIDX_BITS-1];
        addr = w[15:14];
        d = w[DATA_BITS-1:0];
        idx = addr[1];
        if (kind == OP_TICK) begin
            if (ctl_reg[C_RESET]) begin
                acc = '0;
                divider = 1'b0;
            end
            else if (!ctl_reg[C_SLEEP1])
                acc = acc + freq_word[ctl_reg[C_FSELECT]];
        end
        else if (addr == ADDR_CTRL) begin
            ctl_reg = d;
            half_pending = 1'b0;
            if (ctl_reg[C_RESET]) begin
                acc = '0;
                divider = 1'b0;
            end
        end
        else if (addr == ADDR_PHASE)
            pword[w[13]] = w[PWORD_BITS-1:0];
        else if (ctl_reg[C_B28]) begin
            // first half is parked; second write lands the whole word where it points
            if (!half_pending) begin
                half_low = d;
                half_pending = 1'b1;
            end
            else begin
                freq_word[idx] = {d, half_low};
                half_pending = 1'b0;
            end
        end
        else if (ctl_reg[C_HLB])
            freq_word[idx][FREQ_BITS-1:DATA_BITS] = d;
        else
            freq_word[idx][DATA_BITS-1:0] = d;

        p = phase_now();
        if (!prev_msb && p[PIDX_BITS-1])
            divider = ~divider;
        if (ctl_reg[C_RESET])
            divider = 1'b0;

        r.pidx   = p;
        r.tcode  = p[PIDX_BITS-1] ? ~p[PIDX_BITS-2 -: TRI_BITS] : p[PIDX_BITS-2 -: TRI_BITS];
        r.sq     = ctl_reg[C_DIV2] ? p[PIDX_BITS-1] : divider;
        r.wsel   = ctl_reg[C_OPBITEN] ? WAVE_SQUARE :
                   ctl_reg[C_MODE] ? WAVE_TRIANGLE : WAVE_SINE;
        r.asleep = ctl_reg[C_SLEEP12];
        r.ctl    = ctl_reg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic send_request(input logic kind, input logic [WORD_BITS-1:0] w);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        word <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        expected_results.push_back(synth_step(kind, w));
        requests_sent++;
        if (kind == OP_TICK)
            ticks_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_request(OP_TICK, WORD_BITS'($urandom));
    endtask

    task automatic test_half_writes();
        send_request(OP_WRITE, {ADDR_CTRL, 14'h0000});
        send_request(OP_WRITE, {ADDR_FREQ0, 14'h3FFF});
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_HLB)});
        send_request(OP_WRITE, {ADDR_FREQ0, 14'h2AAA});
        send_request(OP_WRITE, {ADDR_FREQ1, 14'h3FFF});
        send_ticks(2);
    endtask

    task automatic test_full_word_writes();
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_B28)});
        send_request(OP_WRITE, {ADDR_FREQ1, 14'h0001});
        // second half addresses freq 0, so the word goes there
        send_request(OP_WRITE, {ADDR_FREQ0, 14'h3FFF});
        send_request(OP_WRITE, {ADDR_FREQ1, 14'h1555});
        // control write drops the parked half
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_B28 | 1 << C_FSELECT)});
        send_request(OP_WRITE, {ADDR_FREQ1, 14'h1234});
        send_request(OP_WRITE, {ADDR_FREQ1, 14'h2000});
        send_ticks(1);
    endtask

    task automatic test_phase_offsets();
        send_request(OP_WRITE, {ADDR_PHASE, 1'b0, 1'b0, 12'hFFF});
        // bit 12 set: must be ignored
        send_request(OP_WRITE, {ADDR_PHASE, 1'b1, 1'b1, 12'h800});
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_PSELECT)});
        send_ticks(1);
    endtask

    task automatic test_output_modes();
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_MODE | 1 << C_DIV2)});
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_MODE | 1 << C_OPBITEN | 1 << C_SLEEP12)});
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_SLEEP1)});
        send_ticks(1);
        send_request(OP_WRITE, {ADDR_CTRL, 14'(1 << C_RESET)});
        send_ticks(1);
        send_request(OP_WRITE, {ADDR_CTRL, 14'h0000});
        send_ticks(1);
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        int block;
        logic [DATA_BITS-1:0] d;
        target = requests_sent + RANDOM_REQUESTS;
        block = 0;
        while (requests_sent < target) begin
            // alternate stretches with and without idle cycles
            idle_on = (block % 3) != 2;
            block++;
            repeat (60) begin
                pick = $urandom_range(0, 99);
                d = DATA_BITS'($urandom);
                if (pick < 50)
                    send_request(OP_TICK, WORD_BITS'($urandom));
                else if (pick < 62) begin
                    // mostly leave the accumulator running
                    if ($urandom_range(0, 9) != 0)
                        d[C_RESET] = 1'b0;
                    if ($urandom_range(0, 5) != 0)
                        d[C_SLEEP1] = 1'b0;
                    send_request(OP_WRITE, {ADDR_CTRL, d});
                end
                else if (pick < 77) begin
                    send_request(OP_WRITE, {$urandom_range(0, 1) ? ADDR_FREQ1 : ADDR_FREQ0, d});
                    if (ctl_reg[C_B28] && half_pending)
                        send_request(OP_WRITE, {$urandom_range(0, 1) ? ADDR_FREQ1 : ADDR_FREQ0,
                                                DATA_BITS'($urandom)});
                end
                else if (pick < 87)
                    send_request(OP_WRITE, {ADDR_PHASE, d});
                else
                    send_request(OP_WRITE, WORD_BITS'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_half_writes();
        test_full_word_writes();
        test_phase_offsets();
        test_output_modes();
        test_random_traffic();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered %0d requests (%0d ticks, %0d command words), %0d results checked",
                 requests_sent, ticks_sent, requests_sent - ticks_sent, results_checked);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : result_sink
        int stall;
        forever begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin
        synth_out_t want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            results_checked++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", {20'd0, phase_index}, 32'd0);
            else begin
                want = expected_results.pop_front();
                if (phase_index !== want.pidx)
                    report_mismatch("phase_index", 32'(phase_index), 32'(want.pidx));
                if (triangle_code !== want.tcode)
                    report_mismatch("triangle_code", 32'(triangle_code), 32'(want.tcode));
                if (square_bit !== want.sq)
                    report_mismatch("square_bit", 32'(square_bit), 32'(want.sq));
                if (waveform !== want.wsel)
                    report_mismatch("waveform", 32'(waveform), 32'(want.wsel));
                if (dac_asleep !== want.asleep)
                    report_mismatch("dac_asleep", 32'(dac_asleep), 32'(want.asleep));
                if (control_readback !== want.ctl)
                    report_mismatch("control_readback", 32'(control_readback),
                                    32'(want.ctl));
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_results.size());
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
